FILE: hdl/ray_box_slab_intersect_macros.svh
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_macros
// assertion shorthands used by the checker module
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// same-cycle implication
`define RBSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RBSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// types, constants and step functions of the ray versus box slab test
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int DIR_WIDTH       = 32;
   localparam int FRAC_BITS       = 30;
   localparam int WIDE_WIDTH      = 80;
   localparam int SQRT_STAGES     = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int OUT_TDATA_WIDTH = 40;

   localparam logic [31:0]            PARALLEL_LIMIT = 32'd1073;
   localparam logic [WIDE_WIDTH-1:0]  T_SAT          = 80'd1 << 62;
   localparam logic [61:0]            P_SAT          = 62'd1 << 61;
   localparam logic [62:0]            H_LIMIT        = 63'd1 << 59;
   localparam logic [31:0]            DIST_MAX       = 32'hFFFF_FFFF;
   localparam logic signed [63:0]     T_POS_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef enum logic {
      CSR_MAX_DISTANCE = 1'b0
   } csr_index_type;

   typedef struct packed {
      logic        ge;
      logic [31:0] rem;
   } div_step_type;

   typedef struct packed {
      logic [63:0] v;
      logic [63:0] res;
   } sqrt_step_type;

   // one restoring division step
   function automatic div_step_type div_step(logic [31:0] rem, logic bit_in,
                                             logic [31:0] dd);
      logic [32:0]  trial;
      div_step_type o;
      trial = {rem, bit_in};
      o.ge  = (trial >= {1'b0, dd});
      o.rem = o.ge ? 32'(trial - {1'b0, dd}) : trial[31:0];
      return o;
   endfunction

   // one digit of the binary square root
   function automatic sqrt_step_type sqrt_step(logic [63:0] v, logic [63:0] res,
                                               logic [63:0] bitv);
      logic [63:0]   rb;
      sqrt_step_type o;
      rb = res + bitv;
      if (v >= rb) begin
         o.v   = v - rb;
         o.res = (res >> 1) + bitv;
      end else begin
         o.v   = v;
         o.res = res >> 1;
      end
      return o;
   endfunction

endpackage

FILE: hdl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// pipelined restoring divider, two dividends over one shared divisor
// ----------------------------------------------------------------------------
module rbsi_div #(
   parameter int DW = 63
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [DW-1:0] dividend_a,
   input  logic [DW-1:0] dividend_b,
   input  logic [31:0]   divisor,
   output logic [DW-1:0] quotient_a,
   output logic [DW-1:0] quotient_b
);
   import rbsi_pkg::*;

   logic [DW-1:0] wa_ff [DW];
   logic [DW-1:0] wb_ff [DW];
   logic [31:0]   ra_ff [DW];
   logic [31:0]   rb_ff [DW];
   logic [31:0]   dd_ff [DW];

   for (genvar g = 0; g < DW; g++) begin : g_stage
      logic [DW-1:0] wa_src, wb_src, wa_in, wb_in;
      logic [31:0]   ra_src, rb_src, dd_src;
      div_step_type  sa, sb;

      if (g == 0) begin : g_first
         assign wa_src = dividend_a;
         assign wb_src = dividend_b;
         assign ra_src = '0;
         assign rb_src = '0;
         assign dd_src = divisor;
      end else begin : g_next
         assign wa_src = wa_ff[g-1];
         assign wb_src = wb_ff[g-1];
         assign ra_src = ra_ff[g-1];
         assign rb_src = rb_ff[g-1];
         assign dd_src = dd_ff[g-1];
      end

      // dividend bits leave at the top, quotient bits enter at the bottom
      always_comb begin
         sa    = div_step(ra_src, wa_src[DW-1], dd_src);
         sb    = div_step(rb_src, wb_src[DW-1], dd_src);
         wa_in = {wa_src[DW-2:0], sa.ge};
         wb_in = {wb_src[DW-2:0], sb.ge};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            wa_ff[g] <= wa_in;
            wb_ff[g] <= wb_in;
            ra_ff[g] <= sa.rem;
            rb_ff[g] <= sb.rem;
            dd_ff[g] <= dd_src;
         end
      end
   end

   assign quotient_a = wa_ff[DW-1];
   assign quotient_b = wb_ff[DW-1];

endmodule

FILE: hdl/rbsi_sqrt.sv
// ----------------------------------------------------------------------------
// rbsi_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module rbsi_sqrt (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import rbsi_pkg::*;

   logic [63:0] v_ff   [SQRT_STAGES];
   logic [63:0] res_ff [SQRT_STAGES];

   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
      localparam logic [63:0] BITV = 64'd1 << (62 - 2 * g);
      logic [63:0]   v_src, res_src;
      sqrt_step_type st;

      if (g == 0) begin : g_first
         assign v_src   = radicand;
         assign res_src = '0;
      end else begin : g_next
         assign v_src   = v_ff[g-1];
         assign res_src = res_ff[g-1];
      end

      assign st = sqrt_step(v_src, res_src, BITV);

      always_ff @(posedge clock) begin
         if (enable) begin
            v_ff[g]   <= st.v;
            res_ff[g] <= st.res;
         end
      end
   end

   assign root = res_ff[SQRT_STAGES-1][31:0];

endmodule

FILE: hdl/rbsi_front.sv
// ----------------------------------------------------------------------------
// rbsi_front
// takes queries, forms slab bounds, flags near-parallel axes, queues them
// ----------------------------------------------------------------------------
module rbsi_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0][COORD_WIDTH-1:0]      org,
   input  logic [2:0][31:0]                 dir,
   input  logic [2:0][COORD_WIDTH-1:0]      ctr,
   input  logic [2:0][COORD_WIDTH-2:0]      half,
   output logic                             q_valid,
   input  logic                             q_ready,
   output logic [2:0][COORD_WIDTH-1:0]      q_org,
   output logic [2:0][31:0]                 q_dir,
   output logic [2:0][COORD_WIDTH:0]        q_lo,
   output logic [2:0][COORD_WIDTH:0]        q_hi,
   output logic [2:0]                       q_par
);
   import rbsi_pkg::*;

   localparam int CW = COORD_WIDTH;

   logic [2:0][CW:0]   lo, hi;
   logic [2:0]         par;
   logic [31:0]        dmag;

   logic [2:0][CW-1:0] org_ff [QUEUE_DEPTH];
   logic [2:0][31:0]   dir_ff [QUEUE_DEPTH];
   logic [2:0][CW:0]   lo_ff  [QUEUE_DEPTH];
   logic [2:0][CW:0]   hi_ff  [QUEUE_DEPTH];
   logic [2:0]         par_ff [QUEUE_DEPTH];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push, pop;

   always_comb begin
      dmag = '0;
      for (int j = 0; j < 3; j++) begin
         lo[j]  = {ctr[j][CW-1], ctr[j]} - {2'b00, half[j]};
         hi[j]  = {ctr[j][CW-1], ctr[j]} + {2'b00, half[j]};
         dmag   = dir[j][31] ? 32'(-dir[j]) : dir[j];
         par[j] = (dmag <= PARALLEL_LIMIT);
      end
   end

   assign req_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != 2'd0);
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         org_ff[wr_ptr_ff] <= org;
         dir_ff[wr_ptr_ff] <= dir;
         lo_ff[wr_ptr_ff]  <= lo;
         hi_ff[wr_ptr_ff]  <= hi;
         par_ff[wr_ptr_ff] <= par;
      end
   end

   assign q_org = org_ff[rd_ptr_ff];
   assign q_dir = dir_ff[rd_ptr_ff];
   assign q_lo  = lo_ff[rd_ptr_ff];
   assign q_hi  = hi_ff[rd_ptr_ff];
   assign q_par = par_ff[rd_ptr_ff];

endmodule

FILE: hdl/rbsi_back.sv
// ----------------------------------------------------------------------------
// rbsi_back
// slab parameters, interval merge, entry point and its length
// ----------------------------------------------------------------------------
module rbsi_back #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  logic [2:0][COORD_WIDTH-1:0] q_org,
   input  logic [2:0][31:0]            q_dir,
   input  logic [2:0][COORD_WIDTH:0]   q_lo,
   input  logic [2:0][COORD_WIDTH:0]   q_hi,
   input  logic [2:0]                  q_par,
   input  logic [31:0]                 max_distance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        hit,
   output logic                        distance_valid,
   output logic [31:0]                 hit_distance
);
   import rbsi_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int NW = CW + 2;
   localparam int MW = CW + 1;
   localparam int DW = MW + FRAC_BITS;

   logic adv;

   // input stages
   logic                b0_valid_ff, b1_valid_ff;
   logic [2:0][NW-1:0]  n1_ff, n2_ff;
   logic [2:0]          inside_ff, par0_ff;
   logic [2:0][CW-1:0]  o0_ff, o1_ff;
   logic [2:0][31:0]    d0_ff;
   logic [2:0][MW-1:0]  m1_ff, m2_ff;
   logic [2:0]          s1_ff, s2_ff, dneg1_ff, par1_ff, inside1_ff;
   logic [2:0][31:0]    dm1_ff;

   // sideband along the divider
   logic               dl_valid_ff  [DW];
   logic [2:0][CW-1:0] dl_o_ff      [DW];
   logic [2:0][31:0]   dl_dm_ff     [DW];
   logic [2:0]         dl_dneg_ff   [DW];
   logic [2:0]         dl_s1_ff     [DW];
   logic [2:0]         dl_s2_ff     [DW];
   logic [2:0]         dl_par_ff    [DW];
   logic [2:0]         dl_inside_ff [DW];
   logic [2:0][DW-1:0] q1, q2;

   // merge and entry point stages
   logic               mv_ff   [10];
   logic [2:0][CW-1:0] mo_ff   [6];
   logic [2:0][31:0]   mdm_ff  [6];
   logic [2:0]         mneg_ff [6];
   logic               mpass_ff[6];

   logic signed [63:0] t1_ff [3], t2_ff [3];
   logic [2:0]         par_c0_ff, inside_c0_ff;
   logic signed [63:0] tl_ff [3], th_ff [3];
   logic [2:0]         ok_ff;
   logic signed [63:0] mxa_ff, mxb_ff, mna_ff, mnb_ff;
   logic               okall2_ff, okall3_ff;
   logic signed [63:0] tmin_ff, tmax_ff;
   logic [62:0]        h_ff [3];
   logic [63:0]        l_ff [3];
   logic [61:0]        prod_ff [3];
   logic signed [63:0] p_ff [3];
   logic [31:0]        a_ff [3];
   logic [2:0]         big7_ff, big8_ff;
   logic [63:0]        sq_ff [3];
   logic [63:0]        sum_ff;
   logic               sat_ff;

   // sideband along the square root
   logic sv_ff [SQRT_STAGES];
   logic sp_ff [SQRT_STAGES];
   logic ss_ff [SQRT_STAGES];
   logic [31:0] root;

   logic        out_valid_ff, out_hit_ff, out_dv_ff;
   logic [31:0] out_dist_ff;

   // next values
   logic [2:0][NW-1:0]  n1_in, n2_in;
   logic [2:0]          inside_in;
   logic [2:0][MW-1:0]  m1_in, m2_in;
   logic [2:0]          s1_in, s2_in;
   logic [2:0][31:0]    dm1_in;
   logic signed [63:0]  t1_in [3], t2_in [3];
   logic signed [63:0]  tl_in [3], th_in [3];
   logic [2:0]          ok_in;
   logic signed [63:0]  mxa_in, mxb_in, mna_in, tmin_in, tmax_in;
   logic                pass_in;
   logic [62:0]         h_in [3];
   logic [63:0]         l_in [3];
   logic [61:0]         prod_in [3];
   logic signed [63:0]  p_in [3];
   logic [31:0]         a_in [3];
   logic [2:0]          big_in;
   logic [63:0]         sq_in [3];
   logic [65:0]         sum_in;
   logic [31:0]         root_sat;

   assign adv     = !out_valid_ff || rsp_ready;
   assign q_ready = adv;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         logic [NW-1:0] oe;
         logic [WIDE_WIDTH-1:0] w1, w2;
         logic [62:0] g1, g2;
         logic [63:0] s64;
         logic signed [63:0] oext;
         logic [63:0] amag;
         oe           = {{2{q_org[j][CW-1]}}, q_org[j]};
         n1_in[j]     = {q_lo[j][CW], q_lo[j]} - oe;
         n2_in[j]     = {q_hi[j][CW], q_hi[j]} - oe;
         inside_in[j] = !($signed(oe) < $signed({q_lo[j][CW], q_lo[j]}) ||
                          $signed(oe) > $signed({q_hi[j][CW], q_hi[j]}));

         m1_in[j]  = n1_ff[j][NW-1] ? MW'(-n1_ff[j]) : MW'(n1_ff[j]);
         m2_in[j]  = n2_ff[j][NW-1] ? MW'(-n2_ff[j]) : MW'(n2_ff[j]);
         s1_in[j]  = n1_ff[j][NW-1] ^ d0_ff[j][31];
         s2_in[j]  = n2_ff[j][NW-1] ^ d0_ff[j][31];
         dm1_in[j] = d0_ff[j][31] ? 32'(-d0_ff[j]) : d0_ff[j];

         // quotient magnitude saturates, then takes the sign
         w1 = WIDE_WIDTH'(q1[j]);
         w2 = WIDE_WIDTH'(q2[j]);
         g1 = (w1 > T_SAT) ? T_SAT[62:0] : w1[62:0];
         g2 = (w2 > T_SAT) ? T_SAT[62:0] : w2[62:0];
         t1_in[j] = dl_s1_ff[DW-1][j] ? -$signed({1'b0, g1}) : $signed({1'b0, g1});
         t2_in[j] = dl_s2_ff[DW-1][j] ? -$signed({1'b0, g2}) : $signed({1'b0, g2});

         // parallel axes leave the interval alone
         if (par_c0_ff[j]) begin
            tl_in[j] = '0;
            th_in[j] = T_POS_MAX;
            ok_in[j] = inside_c0_ff[j];
         end else begin
            tl_in[j] = (t1_ff[j] < t2_ff[j]) ? t1_ff[j] : t2_ff[j];
            th_in[j] = (t1_ff[j] < t2_ff[j]) ? t2_ff[j] : t1_ff[j];
            ok_in[j] = 1'b1;
         end

         h_in[j] = {31'b0, mdm_ff[3][j]} * {32'b0, tmin_ff[62:32]};
         l_in[j] = {32'b0, mdm_ff[3][j]} * {32'b0, tmin_ff[31:0]};

         s64 = {h_ff[j][61:0], 2'b00} + {30'b0, l_ff[j][63:30]};
         if (h_ff[j] >= H_LIMIT) begin
            prod_in[j] = P_SAT;
         end else begin
            prod_in[j] = (s64 > 64'(P_SAT)) ? P_SAT : s64[61:0];
         end

         oext    = $signed({{(64-CW){mo_ff[5][j][CW-1]}}, mo_ff[5][j]});
         p_in[j] = mneg_ff[5][j] ? oext - $signed({2'b00, prod_ff[j]})
                                 : oext + $signed({2'b00, prod_ff[j]});

         amag      = p_ff[j][63] ? 64'(-p_ff[j]) : 64'(p_ff[j]);
         a_in[j]   = amag[31:0];
         big_in[j] = (amag[63:32] != 32'd0);

         sq_in[j] = {32'b0, a_ff[j]} * {32'b0, a_ff[j]};
      end

      mxa_in  = (tl_ff[0] > tl_ff[1]) ? tl_ff[0] : tl_ff[1];
      mxb_in  = (tl_ff[2] > 64'sd0) ? tl_ff[2] : 64'sd0;
      mna_in  = (th_ff[0] < th_ff[1]) ? th_ff[0] : th_ff[1];
      tmin_in = (mxa_ff > mxb_ff) ? mxa_ff : mxb_ff;
      tmax_in = (mna_ff < mnb_ff) ? mna_ff : mnb_ff;
      pass_in = okall3_ff && !(tmin_ff > tmax_ff);
      sum_in  = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
   end

   for (genvar j = 0; j < 3; j++) begin : g_div
      rbsi_div #(.DW(DW)) u_div (
         .clock      (clock),
         .enable     (adv),
         .dividend_a ({m1_ff[j], FRAC_BITS'(0)}),
         .dividend_b ({m2_ff[j], FRAC_BITS'(0)}),
         .divisor    (dm1_ff[j]),
         .quotient_a (q1[j]),
         .quotient_b (q2[j])
      );
   end

   rbsi_sqrt u_sqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (sum_ff),
      .root     (root)
   );

   assign root_sat = ss_ff[SQRT_STAGES-1] ? DIST_MAX : root;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff  <= 1'b0;
         b1_valid_ff  <= 1'b0;
         dl_valid_ff  <= '{default: 1'b0};
         mv_ff        <= '{default: 1'b0};
         sv_ff        <= '{default: 1'b0};
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         b0_valid_ff    <= q_valid;
         b1_valid_ff    <= b0_valid_ff;
         dl_valid_ff[0] <= b1_valid_ff;
         for (int i = 1; i < DW; i++) dl_valid_ff[i] <= dl_valid_ff[i-1];
         mv_ff[0] <= dl_valid_ff[DW-1];
         for (int i = 1; i < 10; i++) mv_ff[i] <= mv_ff[i-1];
         sv_ff[0] <= mv_ff[9];
         for (int i = 1; i < SQRT_STAGES; i++) sv_ff[i] <= sv_ff[i-1];
         out_valid_ff <= sv_ff[SQRT_STAGES-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff     <= n1_in;
         n2_ff     <= n2_in;
         inside_ff <= inside_in;
         par0_ff   <= q_par;
         o0_ff     <= q_org;
         d0_ff     <= q_dir;

         m1_ff      <= m1_in;
         m2_ff      <= m2_in;
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         dm1_ff     <= dm1_in;
         o1_ff      <= o0_ff;
         par1_ff    <= par0_ff;
         inside1_ff <= inside_ff;
         for (int j = 0; j < 3; j++) dneg1_ff[j] <= d0_ff[j][31];

         dl_o_ff[0]      <= o1_ff;
         dl_dm_ff[0]     <= dm1_ff;
         dl_dneg_ff[0]   <= dneg1_ff;
         dl_s1_ff[0]     <= s1_ff;
         dl_s2_ff[0]     <= s2_ff;
         dl_par_ff[0]    <= par1_ff;
         dl_inside_ff[0] <= inside1_ff;
         for (int i = 1; i < DW; i++) begin
            dl_o_ff[i]      <= dl_o_ff[i-1];
            dl_dm_ff[i]     <= dl_dm_ff[i-1];
            dl_dneg_ff[i]   <= dl_dneg_ff[i-1];
            dl_s1_ff[i]     <= dl_s1_ff[i-1];
            dl_s2_ff[i]     <= dl_s2_ff[i-1];
            dl_par_ff[i]    <= dl_par_ff[i-1];
            dl_inside_ff[i] <= dl_inside_ff[i-1];
         end

         mo_ff[0]   <= dl_o_ff[DW-1];
         mdm_ff[0]  <= dl_dm_ff[DW-1];
         mneg_ff[0] <= dl_dneg_ff[DW-1];
         for (int i = 1; i < 6; i++) begin
            mo_ff[i]   <= mo_ff[i-1];
            mdm_ff[i]  <= mdm_ff[i-1];
            mneg_ff[i] <= mneg_ff[i-1];
         end

         t1_ff        <= t1_in;
         t2_ff        <= t2_in;
         par_c0_ff    <= dl_par_ff[DW-1];
         inside_c0_ff <= dl_inside_ff[DW-1];

         tl_ff <= tl_in;
         th_ff <= th_in;
         ok_ff <= ok_in;

         mxa_ff    <= mxa_in;
         mxb_ff    <= mxb_in;
         mna_ff    <= mna_in;
         mnb_ff    <= th_ff[2];
         okall2_ff <= &ok_ff;

         tmin_ff   <= tmin_in;
         tmax_ff   <= tmax_in;
         okall3_ff <= okall2_ff;

         mpass_ff[0] <= pass_in;
         for (int i = 1; i < 6; i++) mpass_ff[i] <= mpass_ff[i-1];
         h_ff    <= h_in;
         l_ff    <= l_in;
         prod_ff <= prod_in;
         p_ff    <= p_in;
         a_ff    <= a_in;
         big7_ff <= big_in;
         sq_ff   <= sq_in;
         big8_ff <= big7_ff;
         sum_ff  <= sum_in[63:0];
         sat_ff  <= (|big8_ff) || (sum_in[65:64] != 2'b00);

         sp_ff[0] <= mpass_ff[5];
         ss_ff[0] <= sat_ff;
         for (int i = 1; i < SQRT_STAGES; i++) begin
            sp_ff[i] <= sp_ff[i-1];
            ss_ff[i] <= ss_ff[i-1];
         end

         // a slab miss reports all zeros
         out_dv_ff   <= sp_ff[SQRT_STAGES-1];
         out_hit_ff  <= sp_ff[SQRT_STAGES-1] && (root_sat <= max_distance);
         out_dist_ff <= sp_ff[SQRT_STAGES-1] ? root_sat : 32'd0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign hit            = out_hit_ff;
   assign distance_valid = out_dv_ff;
   assign hit_distance   = out_dist_ff;

endmodule

FILE: hdl/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// ray against axis-aligned box, slab test with entry distance
// ----------------------------------------------------------------------------
// req_*: one query per transaction (origin, unit direction, box center and
//   half extents); accepted when req_tvalid and req_tready are both high.
// rsp_*: one result per query, in query order: hit and hit_distance in
//   tdata, distance_valid in tuser.
// csr_*: APB register port; max_distance at byte address 0; the user must
//   write it only while the block is idle, which the block does not enforce.
// Throughput: one query per cycle while rsp_tready does not hold the pipeline.
//   Pipeline depth comes mainly from the bit-per-stage slab dividers
//   (COORD_WIDTH + 31 stages) and the 32-stage square root.
// A two-entry queue splits the input side from the compute pipeline, so
//   req_tready only drops after the queue fills.
// When a result is waiting and rsp_tready is low the whole compute pipeline
//   holds and the result waits in the output register.
// Reset clears all valid state and sets max_distance to all ones.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // origin_x/y/z, dir_x/y/z, box_center_x/y/z, box_half_x/y/z, zero pad
   input  logic [((9*COORD_WIDTH+93+7)/8)*8-1:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // hit, hit_distance, zero pad
   output logic [rbsi_pkg::OUT_TDATA_WIDTH-1:0] rsp_tdata,
   // distance_valid
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rbsi_pkg::*;

   localparam int CW = COORD_WIDTH;

   logic [2:0][CW-1:0] org, ctr;
   logic [2:0][31:0]   dir;
   logic [2:0][CW-2:0] half;

   logic               q_valid, q_ready;
   logic [2:0][CW-1:0] q_org;
   logic [2:0][31:0]   q_dir;
   logic [2:0][CW:0]   q_lo, q_hi;
   logic [2:0]         q_par;

   logic [31:0] max_distance_ff, max_distance_in;
   logic        csr_wr;
   logic        hit, distance_valid;
   logic [31:0] hit_distance;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         org[j]  = req_tdata[j*CW +: CW];
         dir[j]  = req_tdata[3*CW + 32*j +: 32];
         ctr[j]  = req_tdata[3*CW + 96 + j*CW +: CW];
         half[j] = req_tdata[6*CW + 96 + j*(CW-1) +: CW-1];
      end
   end

   // register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_index_type'(csr_paddr[2]) == CSR_MAX_DISTANCE);
   assign max_distance_in = csr_wr ? csr_pwdata : max_distance_ff;
   assign csr_prdata = (csr_index_type'(csr_paddr[2]) == CSR_MAX_DISTANCE) ?
                       max_distance_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= DIST_MAX;
      end else begin
         max_distance_ff <= max_distance_in;
      end
   end

   rbsi_front #(.COORD_WIDTH(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .org       (org),
      .dir       (dir),
      .ctr       (ctr),
      .half      (half),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_org     (q_org),
      .q_dir     (q_dir),
      .q_lo      (q_lo),
      .q_hi      (q_hi),
      .q_par     (q_par)
   );

   rbsi_back #(.COORD_WIDTH(CW)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_org          (q_org),
      .q_dir          (q_dir),
      .q_lo           (q_lo),
      .q_hi           (q_hi),
      .q_par          (q_par),
      .max_distance   (max_distance_ff),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .hit            (hit),
      .distance_valid (distance_valid),
      .hit_distance   (hit_distance)
   );

   assign rsp_tdata = {(OUT_TDATA_WIDTH-33)'(0), hit_distance, hit};
   assign rsp_tuser = distance_valid;

endmodule

FILE: hdl/rbsi_checker.sv
// ----------------------------------------------------------------------------
// rbsi_checker
// port-level checks of the ray versus box block
// ----------------------------------------------------------------------------
`include "ray_box_slab_intersect_macros.svh"

module rbsi_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   input logic [((9*COORD_WIDTH+93+7)/8)*8-1:0] req_tdata,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [rbsi_pkg::OUT_TDATA_WIDTH-1:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);
   import rbsi_pkg::*;

   // a stalled result holds
   `RBSI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // a slab miss carries no hit and no distance
   `RBSI_ASSERT_NOW(a_miss_zero, clock, reset, rsp_tvalid && (rsp_tuser == 1'b0), rsp_tdata == '0, "miss with nonzero payload")

   // a hit needs a computed distance
   `RBSI_ASSERT_NOW(a_hit_valid, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tuser[0], "hit without distance_valid")

   // max_distance reads back what was written
   `RBSI_ASSERT_NEXT(a_csr_readback, clock, reset, csr_psel && csr_penable && csr_pwrite && csr_pready && (csr_paddr == 3'd0), (csr_paddr != 3'd0) || (csr_prdata == $past(csr_pwdata)), "max_distance readback mismatch")

endmodule

bind ray_box_slab_intersect rbsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_checker (.*);
